@@ design/lcdst_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdst_pkg
// Shared types and constants for the LCD scanline timing controller.
// ----------------------------------------------------------------------------
package lcdst_pkg;

	// default line geometry
	localparam int unsigned LINE_CYCLES_DEF       = 456;
	localparam int unsigned LAST_VISIBLE_LINE_DEF = 143;
	localparam int unsigned LAST_LINE_DEF         = 153;

	// cycle positions inside a visible line
	localparam logic [9:0] SEARCH_END   = 10'd80;
	localparam logic [9:0] TRANSFER_END = 10'd252;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_SEARCH   = 2'd2,
		MODE_TRANSFER = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISPLAY_ENABLE   = 3'd0,
		CFG_LINE_COMPARE     = 3'd1,
		CFG_IRQ_HBLANK       = 3'd2,
		CFG_IRQ_VBLANK_MODE  = 3'd3,
		CFG_IRQ_SEARCH       = 3'd4,
		CFG_IRQ_MATCH        = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic       display_enable;
		logic [7:0] line_compare;
		logic       irq_hblank_enable;
		logic       irq_vblank_mode_enable;
		logic       irq_search_enable;
		logic       irq_match_enable;
	} cfg_t;

	typedef struct packed {
		logic [9:0] cycle_count;
		logic [7:0] line_number;
		mode_t      mode;
		logic       match_flag;
	} tstate_t;

	typedef struct packed {
		logic vblank_request;
		logic status_request;
		logic draw_line_request;
	} req_t;

endpackage

@@ design/lcdst_cfg.sv @@
// ----------------------------------------------------------------------------
// lcdst_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module lcdst_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lcdst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcdst_pkg::CFG_DATA_W-1:0] cfg_data,
	output lcdst_pkg::cfg_t                  cfg
);
	import lcdst_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DISPLAY_ENABLE:  cfg_q.display_enable         <= cfg_data[0];
				CFG_LINE_COMPARE:    cfg_q.line_compare           <= cfg_data[7:0];
				CFG_IRQ_HBLANK:      cfg_q.irq_hblank_enable      <= cfg_data[0];
				CFG_IRQ_VBLANK_MODE: cfg_q.irq_vblank_mode_enable <= cfg_data[0];
				CFG_IRQ_SEARCH:      cfg_q.irq_search_enable      <= cfg_data[0];
				CFG_IRQ_MATCH:       cfg_q.irq_match_enable       <= cfg_data[0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/lcdst_step.sv @@
// ----------------------------------------------------------------------------
// lcdst_step
// Next-state and request logic for one beat of elapsed cycles.
// ----------------------------------------------------------------------------
module lcdst_step #(
	parameter int unsigned LINE_CYCLES       = lcdst_pkg::LINE_CYCLES_DEF,
	parameter int unsigned LAST_VISIBLE_LINE = lcdst_pkg::LAST_VISIBLE_LINE_DEF,
	parameter int unsigned LAST_LINE         = lcdst_pkg::LAST_LINE_DEF
) (
	input  lcdst_pkg::cfg_t    cfg,
	input  lcdst_pkg::tstate_t cur,
	input  logic [7:0]         cycles,
	output lcdst_pkg::tstate_t nxt,
	output lcdst_pkg::req_t    req
);
	import lcdst_pkg::*;

	localparam logic [9:0] LINE_LEN  = 10'(LINE_CYCLES);
	localparam logic [7:0] LAST_VIS  = 8'(LAST_VISIBLE_LINE);
	localparam logic [7:0] FIRST_VB  = 8'(LAST_VISIBLE_LINE + 1);
	localparam logic [7:0] LAST_LN   = 8'(LAST_LINE);

	mode_t       mode;
	logic        irq_on;
	logic        match;
	logic [9:0]  cnt_add;
	logic        wrap;
	logic [7:0]  line_inc;

	always_comb begin
		// mode from the position before the cycles are added
		if (cur.line_number > LAST_VIS) begin
			mode   = MODE_VBLANK;
			irq_on = cfg.irq_vblank_mode_enable;
		end else if (cur.cycle_count < SEARCH_END) begin
			mode   = MODE_SEARCH;
			irq_on = cfg.irq_search_enable;
		end else if (cur.cycle_count < TRANSFER_END) begin
			mode   = MODE_TRANSFER;
			irq_on = 1'b0;
		end else begin
			mode   = MODE_HBLANK;
			irq_on = cfg.irq_hblank_enable;
		end

		match    = (cur.line_number == cfg.line_compare);
		cnt_add  = cur.cycle_count + {2'b00, cycles};
		wrap     = (cnt_add >= LINE_LEN);
		line_inc = cur.line_number + 8'd1;

		nxt = cur;
		req = '0;
		if (cfg.display_enable) begin
			nxt.mode           = mode;
			nxt.match_flag     = match;
			req.status_request = ((mode != cur.mode) && irq_on)
				|| (match && cfg.irq_match_enable);
			if (wrap) begin
				nxt.cycle_count = '0;
				nxt.line_number = line_inc;
				if (line_inc == FIRST_VB) begin
					req.vblank_request = 1'b1;
				end else if (line_inc > LAST_LN) begin
					nxt.line_number = '0;
				end else if (line_inc <= LAST_VIS) begin
					req.draw_line_request = 1'b1;
				end
			end else begin
				nxt.cycle_count = cnt_add;
			end
		end else begin
			nxt.cycle_count = '0;
			nxt.line_number = '0;
			nxt.mode        = MODE_HBLANK;
		end
	end

endmodule

@@ design/lcd_scanline_timing_controller.sv @@
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller
// Scanline timing for an LCD: display mode, line counter, status, vblank and
// draw requests from a stream of elapsed-cycle counts.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes through the input register, then the
// result register, to its result beat on the output.
// Throughput: one beat per cycle while out_ready holds; the line state updates
// in one pass of the step logic between the input and result registers.
// Reset: arst_n clears all configuration, line state and valid flags.
module lcd_scanline_timing_controller #(
	parameter int unsigned LINE_CYCLES       = lcdst_pkg::LINE_CYCLES_DEF,
	parameter int unsigned LAST_VISIBLE_LINE = lcdst_pkg::LAST_VISIBLE_LINE_DEF,
	parameter int unsigned LAST_LINE         = lcdst_pkg::LAST_LINE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_write,
	input  logic [lcdst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcdst_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       elapsed_cycles,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       current_line,
	output logic [1:0]                       display_mode,
	output logic                             line_match,
	output logic                             vblank_request,
	output logic                             status_request,
	output logic                             draw_line_request
);
	import lcdst_pkg::*;

	cfg_t    cfg;
	tstate_t state_q;
	tstate_t state_nxt;
	req_t    req;

	// input register
	logic       valid_s1;
	logic [7:0] cycles_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] line_q;
	mode_t      mode_q;
	logic       match_q;
	req_t       req_q;

	logic advance;

	lcdst_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcdst_step #(
		.LINE_CYCLES       (LINE_CYCLES),
		.LAST_VISIBLE_LINE (LAST_VISIBLE_LINE),
		.LAST_LINE         (LAST_LINE)
	) u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.cycles (cycles_s1),
		.nxt    (state_nxt),
		.req    (req)
	);

	// Advance the held beat into the result register whenever that register
	// is empty or being drained this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cycles_s1 <= elapsed_cycles;
		end
	end

	// Line state moves only when a beat is committed to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_q  <= state_nxt.line_number;
			mode_q  <= state_nxt.mode;
			match_q <= state_nxt.match_flag;
			req_q   <= req;
		end
	end

	assign out_valid         = out_valid_q;
	assign current_line      = line_q;
	assign display_mode      = 2'(mode_q);
	assign line_match        = match_q;
	assign vblank_request    = req_q.vblank_request;
	assign status_request    = req_q.status_request;
	assign draw_line_request = req_q.draw_line_request;

`ifndef SYNTHESIS
	// line counter stays within the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line_number <= 8'(LAST_LINE))
		else $error("line counter beyond last line");

	// cycle counter clears at the line length
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cycle_count < 10'(LINE_CYCLES))
		else $error("cycle counter reached line length");

	// a disabled display commits line 0 in hblank with no requests
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg.display_enable |=>
			current_line == 8'd0 && mode_q == MODE_HBLANK && req_q == '0)
		else $error("disabled display produced activity");

	// vblank request only on the first blank line
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vblank_request |-> current_line == 8'(LAST_VISIBLE_LINE + 1))
		else $error("vblank request on wrong line");

	// draw request only for visible lines
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && draw_line_request |->
			current_line <= 8'(LAST_VISIBLE_LINE) && !vblank_request)
		else $error("draw request outside visible area");
`endif

endmodule

@@ tb/sv/lcd_scanline_timing_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD scanline timing controller testbench
// Streams elapsed-cycle beats into the controller under several register
// settings, predicts mode, line, match and request outputs per beat, and
// checks every result beat in order against the prediction.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller_tb;
	import lcdst_pkg::*;

	localparam int unsigned LINE_LEN   = LINE_CYCLES_DEF;
	localparam int unsigned LAST_VIS   = LAST_VISIBLE_LINE_DEF;
	localparam int unsigned LAST_LN    = LAST_LINE_DEF;
	localparam int unsigned RUN_LIMIT  = 200000;
	localparam int unsigned SETTLE     = 6;
	localparam int unsigned HOLD_LEN   = 60;

	// one result beat, laid out field by field
	typedef struct packed {
		logic [7:0] line;
		mode_t      mode;
		logic       match;
		logic       vblank;
		logic       status;
		logic       draw;
	} scan_beat_t;

	// Tracks the line timing state and queues the result each input beat causes.
	class scanline_tracker;
		cfg_t        regs;
		logic [9:0]  line_pos;
		logic [7:0]  line;
		mode_t       mode;
		logic        match;
		scan_beat_t  pending_beats[$];
		int unsigned mismatches;

		function void clear();
			regs = '0;
			line_pos = '0;
			line = '0;
			mode = MODE_HBLANK;
			match = 1'b0;
			pending_beats.delete();
			mismatches = 0;
		endfunction

		// Advance the timing state by one beat and queue its result.
		function void take_cycles(logic [7:0] elapsed);
			scan_beat_t want;
			mode_t      next_mode;
			logic       irq_on;
			want = '0;
			if (regs.display_enable) begin
				// mode is decided from the position before the cycles are added
				if (line > LAST_VIS) begin
					next_mode = MODE_VBLANK;
					irq_on = regs.irq_vblank_mode_enable;
				end else if (line_pos < SEARCH_END) begin
					next_mode = MODE_SEARCH;
					irq_on = regs.irq_search_enable;
				end else if (line_pos < TRANSFER_END) begin
					next_mode = MODE_TRANSFER;
					irq_on = 1'b0;
				end else begin
					next_mode = MODE_HBLANK;
					irq_on = regs.irq_hblank_enable;
				end
				if (next_mode != mode && irq_on)
					want.status = 1'b1;
				mode = next_mode;
				match = (line == regs.line_compare);
				if (match && regs.irq_match_enable)
					want.status = 1'b1;
				line_pos = line_pos + elapsed;
				if (line_pos >= LINE_LEN) begin
					line = line + 8'd1;
					line_pos = '0;
					if (line == LAST_VIS + 1)
						want.vblank = 1'b1;
					else if (line > LAST_LN)
						line = '0;
					else if (line <= LAST_VIS)
						want.draw = 1'b1;
				end
			end else begin
				// display off: hold the counters at zero, keep the match flag
				line_pos = '0;
				line = '0;
				mode = MODE_HBLANK;
			end
			want.line = line;
			want.mode = mode;
			want.match = match;
			pending_beats.push_back(want);
		endfunction

		function void cmp_field(string label, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", label, want, got);
				mismatches++;
			end
		endfunction

		// Compare a result beat with the oldest queued prediction.
		function void check_line_beat(scan_beat_t got);
			scan_beat_t want;
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing pending: current_line %0d", got.line);
				mismatches++;
				return;
			end
			want = pending_beats.pop_front();
			cmp_field("current_line", want.line, got.line);
			cmp_field("display_mode", want.mode, got.mode);
			cmp_field("line_match", want.match, got.match);
			cmp_field("vblank_request", want.vblank, got.vblank);
			cmp_field("status_request", want.status, got.status);
			cmp_field("draw_line_request", want.draw, got.draw);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            elapsed_cycles;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            current_line;
	logic [1:0]            display_mode;
	logic                  line_match;
	logic                  vblank_request;
	logic                  status_request;
	logic                  draw_line_request;

	scanline_tracker tracker;
	bit              calm;       // suppress idling on both sides
	bit              hold_go;    // ask the receiver for one long hold-off
	int unsigned     hold_left;
	int unsigned     cycle_total;

	lcd_scanline_timing_controller u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.elapsed_cycles    (elapsed_cycles),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.current_line      (current_line),
		.display_mode      (display_mode),
		.line_match        (line_match),
		.vblank_request    (vblank_request),
		.status_request    (status_request),
		.draw_line_request (draw_line_request)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run: a run that reaches the cycle limit counts as a failure.
	always @(posedge clk) begin
		cycle_total++;
		if (cycle_total >= RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: drop ready at random, or for one long counted stretch on request,
	// so the block backs up and stalls its input side.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 15);
			end
		end
	end

	// Sample result beats at the edge that accepts them; every value read here
	// is the one held before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_line_beat('{
				line:   current_line,
				mode:   mode_t'(display_mode),
				match:  line_match,
				vblank: vblank_request,
				status: status_request,
				draw:   draw_line_request
			});
	end

	// Offer one beat and hold it until the block takes it.
	task automatic send_beat(input logic [7:0] cycles);
		in_valid <= 1'b1;
		elapsed_cycles <= cycles;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_cycles(cycles);
		// idle now and then, but never while the calm stretch runs
		if (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
	endtask

	// Pause the sender until every predicted beat has come back, then settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Write all six registers, one per cycle, and mirror them in the tracker.
	task automatic program_regs(input cfg_t c);
		put_reg(CFG_DISPLAY_ENABLE, {7'd0, c.display_enable});
		put_reg(CFG_LINE_COMPARE, c.line_compare);
		put_reg(CFG_IRQ_HBLANK, {7'd0, c.irq_hblank_enable});
		put_reg(CFG_IRQ_VBLANK_MODE, {7'd0, c.irq_vblank_mode_enable});
		put_reg(CFG_IRQ_SEARCH, {7'd0, c.irq_search_enable});
		put_reg(CFG_IRQ_MATCH, {7'd0, c.irq_match_enable});
		cfg_write <= 1'b0;
		@(posedge clk);
		tracker.regs = c;
	endtask

	// Mostly long steps so whole frames go by, with the extremes and the full
	// range mixed in.
	function automatic logic [7:0] pick_cycles();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 65)
			return 8'($urandom_range(255, 120));
		else if (roll < 72)
			return 8'd255;
		else if (roll < 78)
			return 8'd0;
		else
			return 8'($urandom_range(255, 0));
	endfunction

	task automatic run_phase(input cfg_t c, input int unsigned beats,
			input bit steady, input bit hold_off);
		drain();
		program_regs(c);
		calm = steady;
		if (hold_off)
			hold_go = 1'b1;
		repeat (beats) send_beat(pick_cycles());
	endtask

	initial begin
		// walk one line through search, transfer and hblank at its boundaries
		logic [7:0] line_walk [13];
		cfg_t c;

		line_walk = '{8'd79, 8'd1, 8'd171, 8'd1, 8'd203, 8'd1,
			8'd0, 8'd255, 8'd255, 8'd128, 8'd200, 8'd255, 8'd0};
		tracker = new;
		tracker.clear();
		calm = 1'b0;
		hold_go = 1'b0;
		hold_left = 0;
		cycle_total = 0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		elapsed_cycles <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// display still off after reset: extremes must leave line and mode at zero
		send_beat(8'd0);
		send_beat(8'd255);

		// switch on with every interrupt enabled and compare on line zero
		drain();
		c = '{display_enable: 1'b1, line_compare: 8'd0, irq_hblank_enable: 1'b1,
			irq_vblank_mode_enable: 1'b1, irq_search_enable: 1'b1,
			irq_match_enable: 1'b1};
		program_regs(c);
		foreach (line_walk[i])
			send_beat(line_walk[i]);

		// turn off mid-line: counters clear, match flag holds
		drain();
		c.display_enable = 1'b0;
		program_regs(c);
		send_beat(8'd17);
		send_beat(8'd255);

		// Random phases. The display stays on across the first four so the line
		// counter runs through vblank and wraps at the frame end.
		c = '{display_enable: 1'b1, line_compare: 8'd0, irq_hblank_enable: 1'b1,
			irq_vblank_mode_enable: 1'b1, irq_search_enable: 1'b1,
			irq_match_enable: 1'b1};
		run_phase(c, 180, 1'b0, 1'b0);

		// compare on the first vblank line; long receiver hold at the start
		c = '{display_enable: 1'b1, line_compare: 8'd144, irq_hblank_enable: 1'b1,
			irq_vblank_mode_enable: 1'b0, irq_search_enable: 1'b1,
			irq_match_enable: 1'b0};
		run_phase(c, 150, 1'b0, 1'b1);

		// compare on the last line; no idling on either side
		c = '{display_enable: 1'b1, line_compare: 8'd153, irq_hblank_enable: 1'b0,
			irq_vblank_mode_enable: 1'b1, irq_search_enable: 1'b0,
			irq_match_enable: 1'b1};
		run_phase(c, 150, 1'b1, 1'b0);

		// compare value never reached; all interrupts off
		c = '{display_enable: 1'b1, line_compare: 8'd255, irq_hblank_enable: 1'b0,
			irq_vblank_mode_enable: 1'b0, irq_search_enable: 1'b0,
			irq_match_enable: 1'b0};
		run_phase(c, 150, 1'b0, 1'b0);

		// display off with everything else enabled
		c = '{display_enable: 1'b0, line_compare: 8'($urandom_range(255, 0)),
			irq_hblank_enable: 1'b1, irq_vblank_mode_enable: 1'b1,
			irq_search_enable: 1'b1, irq_match_enable: 1'b1};
		run_phase(c, 40, 1'b0, 1'b0);

		// back on from line zero with a random mix
		c = '{display_enable: 1'b1, line_compare: 8'($urandom_range(153, 0)),
			irq_hblank_enable: 1'($urandom_range(1, 0)),
			irq_vblank_mode_enable: 1'($urandom_range(1, 0)),
			irq_search_enable: 1'($urandom_range(1, 0)),
			irq_match_enable: 1'($urandom_range(1, 0))};
		run_phase(c, 180, 1'b0, 1'b0);

		drain();
		if (tracker.mismatches == 0 && tracker.pending_beats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ lcd_scanline_timing_controller.f @@
design/lcdst_pkg.sv
design/lcdst_cfg.sv
design/lcdst_step.sv
design/lcd_scanline_timing_controller.sv
tb/sv/lcd_scanline_timing_controller_tb.sv
